/* hdl/mxu_pkg.sv */
// shared types and constants for the mips32 integer execute unit
// no dependencies
`default_nettype none
package mxu_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIV_STEPS = 32;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDI, OP_ADDIU, OP_ADDU, OP_CLO, OP_CLZ, OP_SEB, OP_SEH,
        OP_SUB, OP_SUBU, OP_ROTR, OP_ROTRV, OP_SLL, OP_SLLV, OP_SRA, OP_SRAV,
        OP_SRL, OP_SRLV, OP_AND, OP_ANDI, OP_EXT, OP_INS, OP_NOR, OP_OR,
        OP_ORI, OP_WSBH, OP_XOR, OP_XORI, OP_MOVN, OP_MOVZ, OP_SLT, OP_SLTI,
        OP_SLTIU, OP_SLTU, OP_ALIGN, OP_BITSWAP, OP_MUL, OP_MUH, OP_MULU, OP_MUHU,
        OP_DIV, OP_MOD, OP_DIVU, OP_MODU, OP_LSA, OP_AUI, OP_SELNEZ, OP_SELEQZ
    } op_t;

    typedef struct packed {
        logic [5:0]  action;
        logic [4:0]  dest_reg;
        logic [31:0] a_value;
        logic [31:0] b_value;
        logic [31:0] dest_old_value;
        logic [15:0] immediate;
        logic [4:0]  shift_amount;
        logic [4:0]  field_pos;
        logic [5:0]  field_size;
        logic [1:0]  byte_pos;
        logic [1:0]  scale_amount;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_enable;
        logic [4:0]  dest_reg_out;
        logic        divide_by_zero;
    } out_word_t;

    // partial remainder, dividend bits shifting out as the quotient shifts in, divisor
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] den;
    } div_t;

    // everything that rides alongside the divider
    typedef struct packed {
        logic [31:0] res;
        logic        we;
        logic        dz;
        logic [4:0]  rd;
        logic        is_div;
        logic        use_rem;
        logic        neg;
    } side_t;

endpackage
`default_nettype wire

/* hdl/mxu_div_stage.sv */
// one restoring divide step: one quotient bit
// depends on mxu_pkg
`default_nettype none
module mxu_div_stage (
    input  mxu_pkg::div_t d,
    output mxu_pkg::div_t q
);
    import mxu_pkg::*;

    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;

    always_comb
    begin
        trial = {d.rem, d.quo[WORD_W-1]};
        diff  = trial - {1'b0, d.den};
        q.den = d.den;
        if (!diff[WORD_W])
        begin
            q.rem = diff[WORD_W-1:0];
            q.quo = {d.quo[WORD_W-2:0], 1'b1};
        end
        else
        begin
            q.rem = trial[WORD_W-1:0];
            q.quo = {d.quo[WORD_W-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

/* hdl/mips32_integer_execute_unit.sv */
// top level of the mips32 integer execute unit
// depends on mxu_pkg and mxu_div_stage
`default_nettype none
// one word in, one word out, a new word may enter every cycle while the pipe is not
// held. from acceptance to dst a word passes the input register, which loads at the
// accepting edge, the register after the plain alu and the 33x33 multiplier, the
// stages of the pipelined divider (one quotient bit per stage) and the output register.
// every operation walks the full length so results leave in order. the whole pipe
// advances together; it holds only when the output word is valid and stalled, and
// src_stall follows that.
module mips32_integer_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  mxu_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_stall,
    output mxu_pkg::out_word_t dst_word
);
    import mxu_pkg::*;

    logic advance;

    // input register
    in_word_t in_reg;
    logic     in_vld_reg;

    // alu stage signals
    logic [31:0] a, b, sx_imm, msk, res_next, mag_a, mag_b;
    logic        we_next, dz_next, div_next, rem_next, neg_next, sgn_mul, sgn_div;
    logic [32:0] ma, mb;
    logic [65:0] prod;
    logic [5:0]  lz;
    logic [31:0] inv_a;

    // divider pipe
    div_t  dv_reg [0:DIV_STEPS];
    side_t sd_reg [0:DIV_STEPS];
    logic  vl_reg [0:DIV_STEPS];
    div_t  dv_next [0:DIV_STEPS-1];
    div_t  dv0_next;
    side_t sd0_next;

    // output register
    out_word_t out_reg;
    logic      out_vld_reg;
    logic [31:0] fin_val;

    assign advance   = !out_vld_reg || !dst_stall;
    assign src_stall = !advance;
    assign dst_valid = out_vld_reg;
    assign dst_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (advance)
            in_vld_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            in_reg <= src_word;
    end

    assign a      = in_reg.a_value;
    assign b      = in_reg.b_value;
    assign sx_imm = {{16{in_reg.immediate[15]}}, in_reg.immediate};
    assign msk    = (in_reg.field_size >= 6'd32) ? 32'hFFFF_FFFF
                  : ((32'd1 << in_reg.field_size[4:0]) - 32'd1);
    assign inv_a  = ~a;

    // one multiplier serves all four multiply flavors
    assign sgn_mul = (in_reg.action == OP_MUH);
    assign ma      = {sgn_mul & a[31], a};
    assign mb      = {sgn_mul & b[31], b};
    assign prod    = 66'($signed(ma) * $signed(mb));

    assign sgn_div = (in_reg.action == OP_DIV) || (in_reg.action == OP_MOD);
    assign mag_a   = (sgn_div && a[31]) ? (32'd0 - a) : a;
    assign mag_b   = (sgn_div && b[31]) ? (32'd0 - b) : b;

    // leading zero count of a, or of ~a for clo
    always_comb
    begin
        lz = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if ((in_reg.action == OP_CLO) ? inv_a[i] : a[i])
                lz = 6'(31 - i);
        end
    end

    always_comb
    begin
        res_next = 32'd0;
        we_next  = 1'b1;
        dz_next  = 1'b0;
        div_next = 1'b0;
        rem_next = 1'b0;
        neg_next = 1'b0;
        case (in_reg.action)
            OP_ADD, OP_ADDU:   res_next = a + b;
            OP_ADDI, OP_ADDIU: res_next = a + sx_imm;
            OP_CLO, OP_CLZ:    res_next = {26'd0, lz};
            OP_SEB:            res_next = {{24{a[7]}}, a[7:0]};
            OP_SEH:            res_next = {{16{a[15]}}, a[15:0]};
            OP_SUB, OP_SUBU:   res_next = a - b;
            OP_ROTR:           res_next = 32'({a, a} >> in_reg.shift_amount);
            OP_ROTRV:          res_next = 32'({a, a} >> b[4:0]);
            OP_SLL:            res_next = a << in_reg.shift_amount;
            OP_SLLV:           res_next = a << b[4:0];
            OP_SRA:            res_next = $unsigned($signed(a) >>> in_reg.shift_amount);
            OP_SRAV:           res_next = $unsigned($signed(a) >>> b[4:0]);
            OP_SRL:            res_next = a >> in_reg.shift_amount;
            OP_SRLV:           res_next = a >> b[4:0];
            OP_AND:            res_next = a & b;
            OP_ANDI:           res_next = a & {16'd0, in_reg.immediate};
            OP_EXT:            res_next = (a >> in_reg.field_pos) & msk;
            OP_INS:            res_next = (in_reg.dest_old_value & ~(msk << in_reg.field_pos))
                                        | ((a & msk) << in_reg.field_pos);
            OP_NOR:            res_next = ~(a | b);
            OP_OR:             res_next = a | b;
            OP_ORI:            res_next = a | {16'd0, in_reg.immediate};
            OP_WSBH:           res_next = {a[23:16], a[31:24], a[7:0], a[15:8]};
            OP_XOR:            res_next = a ^ b;
            OP_XORI:           res_next = a ^ {16'd0, in_reg.immediate};
            OP_MOVN:
            begin
                res_next = (b != 32'd0) ? a : in_reg.dest_old_value;
                we_next  = (b != 32'd0);
            end
            OP_MOVZ:
            begin
                res_next = (b == 32'd0) ? a : in_reg.dest_old_value;
                we_next  = (b == 32'd0);
            end
            OP_SLT:            res_next = {31'd0, $signed(a) < $signed(b)};
            OP_SLTI:           res_next = {31'd0, $signed(a) < $signed(sx_imm)};
            OP_SLTIU:          res_next = {31'd0, a < sx_imm};
            OP_SLTU:           res_next = {31'd0, a < b};
            OP_ALIGN:
            begin
                case (in_reg.byte_pos)
                    2'd1:    res_next = {b[23:0], a[31:24]};
                    2'd2:    res_next = {b[15:0], a[31:16]};
                    2'd3:    res_next = {b[7:0], a[31:8]};
                    default: res_next = b;
                endcase
            end
            OP_BITSWAP:
            begin
                for (int i = 0; i < 32; i++)
                    res_next[(i & ~7) | (7 - (i & 7))] = b[i];
            end
            OP_MUL, OP_MULU:   res_next = prod[31:0];
            OP_MUH, OP_MUHU:   res_next = prod[63:32];
            OP_DIV, OP_MOD, OP_DIVU, OP_MODU:
            begin
                dz_next  = (b == 32'd0);
                div_next = (b != 32'd0);
                rem_next = (in_reg.action == OP_MOD) || (in_reg.action == OP_MODU);
                if (in_reg.action == OP_DIV)
                    neg_next = a[31] ^ b[31];
                else if (in_reg.action == OP_MOD)
                    neg_next = a[31];
            end
            OP_LSA:            res_next = (a << ({1'b0, in_reg.scale_amount} + 3'd1)) + b;
            OP_AUI:            res_next = a + {in_reg.immediate, 16'd0};
            OP_SELNEZ:         res_next = (b != 32'd0) ? a : 32'd0;
            OP_SELEQZ:         res_next = (b == 32'd0) ? a : 32'd0;
            default:           we_next  = 1'b0;
        endcase
    end

    assign dv0_next = '{rem: '0, quo: mag_a, den: mag_b};
    assign sd0_next = '{res: res_next, we: we_next, dz: dz_next, rd: in_reg.dest_reg,
                        is_div: div_next, use_rem: rem_next, neg: neg_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vl_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            vl_reg[0] <= in_vld_reg;
            for (int k = 0; k < DIV_STEPS; k++)
                vl_reg[k+1] <= vl_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_reg[0] <= dv0_next;
            sd_reg[0] <= sd0_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_reg[k+1] <= dv_next[k];
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    // pipelined divider, one quotient bit per stage
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        mxu_div_stage u_step (
            .d (dv_reg[g]),
            .q (dv_next[g])
        );
    end

    // quotient or remainder pick for the divide family, negated at the output register when needed
    assign fin_val = sd_reg[DIV_STEPS].use_rem ? dv_reg[DIV_STEPS].rem
                                               : dv_reg[DIV_STEPS].quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= vl_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.result_value   <= !sd_reg[DIV_STEPS].is_div ? sd_reg[DIV_STEPS].res
                                    : sd_reg[DIV_STEPS].neg ? (32'd0 - fin_val) : fin_val;
            out_reg.write_enable   <= sd_reg[DIV_STEPS].we;
            out_reg.dest_reg_out   <= sd_reg[DIV_STEPS].rd;
            out_reg.divide_by_zero <= sd_reg[DIV_STEPS].dz;
        end
    end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for the mips32 integer execute unit: directed and random operations
// checked against a behavioral predictor; depends on mxu_pkg and the unit's rtl
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mxu_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_word_t  src_word = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    out_word_t dst_word;

    // pipeline depth, used for the end drain
    localparam int PIPE_DEPTH = 34;

    mips32_integer_execute_unit dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
        .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_word(dst_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    out_word_t pending_results[$];
    int        mismatches = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    bit        hold_off = 1'b0;     // long receiver stall request
    int        hold_cycles = 0;
    int        rx_wait = 0;         // cycles the receiver still holds off

    // count of leading zero bits
    function automatic logic [31:0] lead_zero_count(logic [31:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[31-n])
            n++;
        return n;
    endfunction

    // alu predictor: what the unit should produce for one input word
    function automatic out_word_t alu_predict(in_word_t w);
        out_word_t   o;
        logic [31:0] a, b, r, msk, qu, rm, ma, mb, simm;
        logic [63:0] prod;
        logic [4:0]  vs;
        a = w.a_value;
        b = w.b_value;
        vs = b[4:0];
        simm = {{16{w.immediate[15]}}, w.immediate};
        msk = (w.field_size >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w.field_size) - 1);
        r = '0;
        o.write_enable = 1'b1;
        o.divide_by_zero = 1'b0;
        o.dest_reg_out = w.dest_reg;
        case (w.action)
            OP_ADD, OP_ADDU:     r = a + b;
            OP_ADDI, OP_ADDIU:   r = a + simm;
            OP_CLO:              r = lead_zero_count(~a);
            OP_CLZ:              r = lead_zero_count(a);
            OP_SEB:              r = {{24{a[7]}}, a[7:0]};
            OP_SEH:              r = {{16{a[15]}}, a[15:0]};
            OP_SUB, OP_SUBU:     r = a - b;
            OP_ROTR:             r = 32'({a, a} >> w.shift_amount);
            OP_ROTRV:            r = 32'({a, a} >> vs);
            OP_SLL:              r = a << w.shift_amount;
            OP_SLLV:             r = a << vs;
            OP_SRA:              r = $signed(a) >>> w.shift_amount;
            OP_SRAV:             r = $signed(a) >>> vs;
            OP_SRL:              r = a >> w.shift_amount;
            OP_SRLV:             r = a >> vs;
            OP_AND:              r = a & b;
            OP_ANDI:             r = a & {16'd0, w.immediate};
            OP_EXT:              r = (a >> w.field_pos) & msk;
            OP_INS:              r = (w.dest_old_value & ~(msk << w.field_pos))
                                     | ((a & msk) << w.field_pos);
            OP_NOR:              r = ~(a | b);
            OP_OR:               r = a | b;
            OP_ORI:              r = a | {16'd0, w.immediate};
            OP_WSBH:             r = {a[23:16], a[31:24], a[7:0], a[15:8]};
            OP_XOR:              r = a ^ b;
            OP_XORI:             r = a ^ {16'd0, w.immediate};
            OP_MOVN, OP_MOVZ:
            begin
                if ((b != 0) == (w.action == OP_MOVN))
                    r = a;
                else
                begin
                    r = w.dest_old_value;
                    o.write_enable = 1'b0;
                end
            end
            OP_SLT:              r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            OP_SLTI:             r = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            OP_SLTIU:            r = (a < simm) ? 32'd1 : 32'd0;
            OP_SLTU:             r = (a < b) ? 32'd1 : 32'd0;
            OP_ALIGN:            r = (w.byte_pos == 0) ? b
                                     : ((b << (8 * w.byte_pos)) | (a >> (32 - 8 * w.byte_pos)));
            OP_BITSWAP:
                for (int i = 0; i < 32; i++)
                    r[(i & ~7) | (7 - (i & 7))] = b[i];
            OP_MUL, OP_MULU:     r = a * b;
            OP_MUH:
            begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                r = prod[63:32];
            end
            OP_MUHU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                r = prod[63:32];
            end
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    qu = ma / mb;
                    rm = ma % mb;
                    if (w.action == OP_DIV)
                        r = (a[31] ^ b[31]) ? -qu : qu;
                    else
                        r = a[31] ? -rm : rm;
                end
            end
            OP_DIVU, OP_MODU:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                    r = (w.action == OP_DIVU) ? a / b : a % b;
            end
            OP_LSA:              r = (a << (w.scale_amount + 1)) + b;
            OP_AUI:              r = a + {w.immediate, 16'd0};
            OP_SELNEZ:           r = (b != 0) ? a : 32'd0;
            OP_SELEQZ:           r = (b != 0) ? 32'd0 : a;
            default:             o.write_enable = 1'b0;
        endcase
        o.result_value = r;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t rand_word(int op_lo, int op_hi);
        in_word_t w;
        w.action = 6'($urandom_range(op_lo, op_hi));
        w.dest_reg = 5'($urandom);
        w.a_value = rand_operand();
        w.b_value = rand_operand();
        w.dest_old_value = $urandom;
        w.immediate = 16'($urandom);
        w.shift_amount = 5'($urandom);
        w.field_pos = 5'($urandom);
        w.field_size = 6'($urandom);  // full 6-bit range, sizes 0 and above 32 included
        w.byte_pos = 2'($urandom);
        w.scale_amount = 2'($urandom);
        return w;
    endfunction

    // send one word: random idle gap first, then hold until accepted
    // valid stays high afterwards; whoever stops sending drops it
    task automatic send_word(in_word_t w, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0);
        repeat (gap)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_word <= w;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        pending_results.push_back(alu_predict(w));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // checker: compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            words_checked++;
            rx_wait = $urandom_range(0, 3);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", dst_word);
            end
            else
            begin
                want = pending_results.pop_front();
                if (dst_word !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected val %h we %b rd %0d dz %b, got val %h we %b rd %0d dz %b",
                                 want.result_value, want.write_enable, want.dest_reg_out,
                                 want.divide_by_zero, dst_word.result_value,
                                 dst_word.write_enable, dst_word.dest_reg_out,
                                 dst_word.divide_by_zero);
                end
            end
        end
    end

    // receiver stall: a random wait per word, or a long hold when requested
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            dst_stall <= 1'b1;
            hold_cycles++;
        end
        else if (rx_wait > 0)
        begin
            dst_stall <= 1'b1;
            rx_wait--;
        end
        else
            dst_stall <= 1'b0;
    end

    // every opcode once, with the edge cases that matter
    task automatic test_directed();
        in_word_t w;
        w = '0;
        w.a_value = 32'h8000_0000;
        w.b_value = 32'hFFFF_FFFF;
        w.immediate = 16'h8000;
        w.field_size = 6'd32;
        w.dest_reg = 5'd31;
        for (int op = 0; op < 48; op++)
        begin
            w.action = 6'(op);
            send_word(w);
        end
        // clz of zero, shift by zero, size zero, move not taken, divide by zero
        w = '0;
        w.dest_old_value = 32'hDEAD_BEEF;
        w.a_value = 32'd0;
        w.action = OP_CLZ;   send_word(w);
        w.a_value = 32'hFFFF_FFFF;
        w.action = OP_CLO;   send_word(w);
        w.action = OP_ROTR;  send_word(w);
        w.action = OP_SRA;   send_word(w);
        w.action = OP_EXT;   send_word(w);
        w.action = OP_INS;   send_word(w);
        w.action = OP_MOVN;  send_word(w);
        w.action = OP_DIV;   send_word(w);
        w.action = OP_MODU;  send_word(w);
        w.field_pos = 5'd31; w.field_size = 6'd63;
        w.action = OP_INS;   send_word(w);
        w.a_value = 32'h8000_0000; w.b_value = 32'hFFFF_FFFF;
        w.action = OP_DIV;   send_word(w);
        w.action = OP_MOD;   send_word(w);
        w.action = 6'd63;    send_word(w);
        w.action = 6'd48;    send_word(w);
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < 700; i++)
            send_word(rand_word(0, (i % 20 == 0) ? 63 : 47));
    endtask

    // fill the pipe while the receiver holds off, drain, then mul and div words
    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off = 1'b1;
        fork
            while (hold_cycles < 60)
                @(negedge clk);
            for (int i = 0; i < 50; i++)
                send_word(rand_word(0, 47), 1'b1);
        join_any
        while (hold_cycles < 60)
            @(negedge clk);
        hold_off = 1'b0;
        wait fork;
        wait_drained();
        for (int i = 0; i < 40; i++)
            send_word(rand_word(36, 43), 1'b1);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (PIPE_DEPTH + 5) @(negedge clk);
        $display("sent %0d words, checked %0d results, all 48 ops plus unknown codes",
                 words_sent, words_checked);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("mips32_integer_execute_unit test passed");
        else
            $display("mips32_integer_execute_unit test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("mips32_integer_execute_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
